FILE: hw/rtl/http_header_end_and_type_scan_assert.svh
// Assertion macros for the header scanner checker.
`ifndef HTTP_HEADER_END_AND_TYPE_SCAN_ASSERT_SVH
`define HTTP_HEADER_END_AND_TYPE_SCAN_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HHS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("header scan assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define HHS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("header scan assertion failed");

`endif

FILE: hw/rtl/hhs_pkg.sv
// Types, constants and string tables for the HTTP header scanner.
package hhs_pkg;

    // Reply size limit and byte counter width
    localparam int unsigned MAX_REPLY_BYTES = 16777216;
    localparam int unsigned CNT_W           = $clog2(MAX_REPLY_BYTES + 1);
    localparam int unsigned LEN_W           = 25;
    localparam logic [LEN_W-1:0] LEN_FIELD_MAX = '1;

    // Control characters
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_NUL = 8'h00;

    localparam int unsigned NUM_SPELLINGS = 4;
    localparam int unsigned NUM_TYPES     = 5;
    localparam int unsigned NAME_LEN      = 13;
    localparam int unsigned TYPE_MAX_LEN  = 24;
    localparam logic [4:0]  VIDX_MAX      = 5'd31;

    // Name spellings, first character in the top byte
    localparam logic [8*NAME_LEN-1:0] NAME_TAB [NUM_SPELLINGS] = '{
        "Content-Type:", "content-type:", "Content-type:", "CONTENT-TYPE:"
    };

    // Value prefixes, right-aligned: last character in the low byte
    localparam logic [8*TYPE_MAX_LEN-1:0] TYPE_TAB [NUM_TYPES] = '{
        "application/pdf", "application/msword", "application/vnd.ms-excel",
        "application/mspowerpoint", "application/postscript"
    };
    localparam int unsigned TYPE_LEN [NUM_TYPES] = '{15, 18, 24, 24, 22};

    typedef enum logic [1:0] {
        PH_SEARCH,
        PH_SKIP,
        PH_MATCH,
        PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        KIND_UNKNOWN,
        KIND_PDF,
        KIND_WORD,
        KIND_EXCEL,
        KIND_POWERPOINT,
        KIND_POSTSCRIPT
    } kind_t;

    // Priority chain between spelling cells
    typedef struct packed {
        logic  found;
        kind_t kind;
    } chain_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic             header_found;
        logic [LEN_W-1:0] header_length;
        logic [2:0]       content_kind;
        logic             needs_conversion;
    } out_item_t;

    // Character idx of spelling k
    function automatic logic [7:0] name_char(input logic [1:0] k, input logic [3:0] idx);
        int unsigned base;
        base = 8 * (NAME_LEN - 1 - int'(idx));
        if (int'(idx) < NAME_LEN) begin
            return NAME_TAB[k][base +: 8];
        end
        return CH_NUL;
    endfunction

    // Character vi of value prefix j
    function automatic logic [7:0] type_char(input int unsigned j, input logic [4:0] vi);
        int unsigned base;
        base = 0;
        if (int'(vi) < TYPE_LEN[j]) begin
            base = 8 * (TYPE_LEN[j] - 1 - int'(vi));
            return TYPE_TAB[j][base +: 8];
        end
        return CH_NUL;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] b);
        if (b >= 8'h41 && b <= 8'h5A) begin
            return b + 8'h20;
        end
        return b;
    endfunction

    // Saturate the byte count into the length field
    function automatic logic [LEN_W-1:0] sat_len(input logic [CNT_W-1:0] c);
        if (64'(c) > 64'(LEN_FIELD_MAX)) begin
            return LEN_FIELD_MAX;
        end
        return LEN_W'(c);
    endfunction

endpackage

FILE: hw/rtl/hhs_spell_cell.sv
// One spelling matcher cell: name search, blank skip and value match.
module hhs_spell_cell (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  logic             clear,
    input  logic [7:0]       data_byte,
    input  logic             zero_seen,
    input  logic [1:0]       sel,
    input  hhs_pkg::chain_t  chain_in,
    output hhs_pkg::chain_t  chain_out
);

    logic [3:0]      idx_reg, idx_next;
    hhs_pkg::phase_t ph_reg, ph_next;
    logic [4:0]      cand_reg, cand_next;
    logic [4:0]      vidx_reg, vidx_next;
    hhs_pkg::kind_t  res_reg, res_next;

    logic [7:0] lb;
    logic [4:0] vi;
    logic [4:0] cand;
    logic [4:0] keep;
    logic       hit;
    logic       skip;

    hhs_pkg::phase_t ph_eff;
    hhs_pkg::kind_t  res_eff;

    // Next state for this spelling on one scanned byte
    always_comb begin
        idx_next  = idx_reg;
        ph_next   = ph_reg;
        cand_next = cand_reg;
        vidx_next = vidx_reg;
        res_next  = res_reg;
        lb        = hhs_pkg::to_lower(data_byte);
        skip      = (ph_reg == hhs_pkg::PH_SKIP);
        vi        = skip ? 5'd0 : vidx_reg;
        cand      = skip ? 5'h1F : cand_reg;
        keep      = '0;
        hit       = 1'b0;
        unique case (ph_reg)
            hhs_pkg::PH_SEARCH: begin
                if (!zero_seen) begin
                    if (int'(idx_reg) < hhs_pkg::NAME_LEN &&
                        data_byte == hhs_pkg::name_char(sel, idx_reg)) begin
                        idx_next = idx_reg + 4'd1;
                    end else begin
                        idx_next = (data_byte == hhs_pkg::name_char(sel, 4'd0)) ? 4'd1 : 4'd0;
                    end
                    if (int'(idx_next) >= hhs_pkg::NAME_LEN) begin
                        ph_next = hhs_pkg::PH_SKIP;
                    end
                end
            end
            hhs_pkg::PH_SKIP, hhs_pkg::PH_MATCH: begin
                if (!(skip && (data_byte == hhs_pkg::CH_SP || data_byte == hhs_pkg::CH_TAB))) begin
                    if (skip) begin
                        ph_next   = hhs_pkg::PH_MATCH;
                        vidx_next = 5'd0;
                        cand_next = 5'h1F;
                    end
                    // A full prefix followed by one more byte decides the type
                    for (int j = 0; j < hhs_pkg::NUM_TYPES; j++) begin
                        if (!hit && cand[j] && hhs_pkg::TYPE_LEN[j] == int'(vi)) begin
                            hit      = 1'b1;
                            res_next = hhs_pkg::kind_t'(3'(j + 1));
                            ph_next  = hhs_pkg::PH_DONE;
                        end
                    end
                    if (!hit) begin
                        for (int j = 0; j < hhs_pkg::NUM_TYPES; j++) begin
                            keep[j] = cand[j] && int'(vi) < hhs_pkg::TYPE_LEN[j] &&
                                      hhs_pkg::type_char(j, vi) == lb;
                        end
                        cand_next = keep;
                        if (keep == 5'd0) begin
                            res_next = hhs_pkg::KIND_UNKNOWN;
                            ph_next  = hhs_pkg::PH_DONE;
                        end else if (vi < hhs_pkg::VIDX_MAX) begin
                            vidx_next = vi + 5'd1;
                        end
                    end
                end
            end
            hhs_pkg::PH_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // State registers; end of reply returns to reset values
    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            idx_reg  <= 4'd0;
            ph_reg   <= hhs_pkg::PH_SEARCH;
            cand_reg <= 5'h1F;
            vidx_reg <= 5'd0;
            res_reg  <= hhs_pkg::KIND_UNKNOWN;
        end else if (step) begin
            idx_reg  <= idx_next;
            ph_reg   <= ph_next;
            cand_reg <= cand_next;
            vidx_reg <= vidx_next;
            res_reg  <= res_next;
        end
    end

    // Priority hand-off: the first cell past search decides the kind
    assign ph_eff  = step ? ph_next : ph_reg;
    assign res_eff = step ? res_next : res_reg;

    always_comb begin
        chain_out.found = chain_in.found || (ph_eff != hhs_pkg::PH_SEARCH);
        if (chain_in.found) begin
            chain_out.kind = chain_in.kind;
        end else if (ph_eff == hhs_pkg::PH_DONE) begin
            chain_out.kind = res_eff;
        end else begin
            chain_out.kind = hhs_pkg::KIND_UNKNOWN;
        end
    end

endmodule

FILE: hw/rtl/http_header_end_and_type_scan.sv
// The result item is registered in the output register at the edge that takes the last byte.
// Throughput: one byte per cycle unless stalled; cells step on header bytes up to the limit.
// Input stalls, on any byte, only while a result waits unaccepted in the output register.
// Reset (aresetn low, synchronous) clears all scan state and the output valid.
// Scan state also returns to its reset values after each reply's last byte.
module http_header_end_and_type_scan (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  hhs_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output hhs_pkg::out_item_t m_item
);

    logic [hhs_pkg::CNT_W-1:0] cnt_reg, cnt_eff;
    logic [7:0]                rb_reg [3];
    logic                      done_reg, done_eff;
    logic                      zero_reg;
    logic                      m_valid_reg;
    hhs_pkg::out_item_t        m_item_reg;

    logic            acc;
    logic            active;
    logic            last_acc;
    logic            boundary;
    logic [7:0]      b;
    hhs_pkg::chain_t chain [hhs_pkg::NUM_SPELLINGS+1];

    assign b        = s_item.data_byte;
    assign s_ready  = !m_valid_reg || m_ready;
    assign acc      = s_valid && s_ready;
    assign last_acc = acc && s_item.last_byte;
    assign active   = acc && !done_reg && (cnt_reg < hhs_pkg::CNT_W'(hhs_pkg::MAX_REPLY_BYTES));

    // Boundary detect; recent bytes reset to zero, so no count guard is needed
    assign boundary =
        (rb_reg[0] == hhs_pkg::CH_CR && b == hhs_pkg::CH_CR) ||
        (rb_reg[0] == hhs_pkg::CH_LF && b == hhs_pkg::CH_LF) ||
        (rb_reg[2] == hhs_pkg::CH_CR && rb_reg[1] == hhs_pkg::CH_LF &&
         rb_reg[0] == hhs_pkg::CH_CR && b == hhs_pkg::CH_LF) ||
        (rb_reg[2] == hhs_pkg::CH_LF && rb_reg[1] == hhs_pkg::CH_CR &&
         rb_reg[0] == hhs_pkg::CH_LF && b == hhs_pkg::CH_CR);

    assign done_eff = done_reg || (active && boundary);
    assign cnt_eff  = cnt_reg + hhs_pkg::CNT_W'(active);

    // Row of spelling cells, priority passed from cell to cell
    assign chain[0] = '{found: 1'b0, kind: hhs_pkg::KIND_UNKNOWN};

    for (genvar k = 0; k < hhs_pkg::NUM_SPELLINGS; k++) begin : g_cell
        hhs_spell_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .step      (active),
            .clear     (last_acc),
            .data_byte (b),
            .zero_seen (zero_reg),
            .sel       (2'(k)),
            .chain_in  (chain[k]),
            .chain_out (chain[k+1])
        );
    end

    // Scan state
    always_ff @(posedge aclk) begin
        if (!aresetn || last_acc) begin
            cnt_reg  <= '0;
            rb_reg   <= '{default: 8'h00};
            done_reg <= 1'b0;
            zero_reg <= 1'b0;
        end else if (active) begin
            cnt_reg   <= cnt_eff;
            rb_reg[2] <= rb_reg[1];
            rb_reg[1] <= rb_reg[0];
            rb_reg[0] <= b;
            done_reg  <= done_eff;
            zero_reg  <= zero_reg || (b == hhs_pkg::CH_NUL);
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (last_acc) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (last_acc) begin
            m_item_reg.header_found     <= done_eff;
            m_item_reg.header_length    <= done_eff ? hhs_pkg::sat_len(cnt_eff) : '0;
            m_item_reg.content_kind     <= done_eff ? chain[hhs_pkg::NUM_SPELLINGS].kind
                                                    : hhs_pkg::KIND_UNKNOWN;
            m_item_reg.needs_conversion <= done_eff &&
                (chain[hhs_pkg::NUM_SPELLINGS].kind != hhs_pkg::KIND_UNKNOWN);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

FILE: hw/rtl/hhs_checker.sv
// Port-level checker for the HTTP header scanner, bound to the top level.
`include "http_header_end_and_type_scan_assert.svh"

module hhs_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input hhs_pkg::in_item_t  s_item,
    input logic               m_valid,
    input logic               m_ready,
    input hhs_pkg::out_item_t m_item
);

    logic last_in;
    logic res_empty;
    logic kind_known;

    assign last_in    = s_valid && s_ready && s_item.last_byte;
    assign res_empty  = (m_item.header_length == '0) &&
                        (m_item.content_kind == hhs_pkg::KIND_UNKNOWN) &&
                        !m_item.needs_conversion;
    assign kind_known = (m_item.content_kind != hhs_pkg::KIND_UNKNOWN);

    // Input stalls only behind a waiting result
    `HHS_ASSERT_IMP(a_stall_only_full, aclk, aresetn, !s_ready, m_valid && !m_ready)

    // A taken last byte gives a result in the next cycle
    `HHS_ASSERT_NEXT(a_last_gives_result, aclk, aresetn, last_in, m_valid)

    // Stalled result holds
    `HHS_ASSERT_NEXT(a_result_holds, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_item))

    // No boundary means empty length and unknown kind
    `HHS_ASSERT_IMP(a_not_found_empty, aclk, aresetn, m_valid && !m_item.header_found, res_empty)

    // Conversion flag follows the kind
    `HHS_ASSERT_IMP(a_conv_flag, aclk, aresetn, m_valid, m_item.needs_conversion == kind_known)

endmodule

bind http_header_end_and_type_scan hhs_checker u_hhs_checker (.*);

FILE: sim/tb_top.sv
// Self-checking testbench for the HTTP reply header end and content-type scanner.
module tb_top;

    localparam int unsigned REPLY_LIMIT  = 16777216;
    localparam int unsigned LEN_CAP      = 33554431;
    localparam int unsigned LIMIT_CYCLES = 20000;
    localparam logic [7:0]  BYTE_CR      = 8'h0D;
    localparam logic [7:0]  BYTE_LF      = 8'h0A;
    localparam logic [7:0]  BYTE_SP      = 8'h20;
    localparam logic [7:0]  BYTE_TAB     = 8'h09;
    localparam logic [7:0]  BYTE_NUL     = 8'h00;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    hhs_pkg::in_item_t  s_item  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    hhs_pkg::out_item_t m_item;

    http_header_end_and_type_scan dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    // 12-unit clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Handshake pressure, percent of cycles
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    int unsigned cycle_cnt    = 0;
    int          errors       = 0;
    int          bytes_sent   = 0;
    int          replies_sent = 0;
    int          results_seen = 0;
    int          typed_seen   = 0;

    // Header names and document prefixes searched by the scanner
    string spelling_txt [4] = '{"Content-Type:", "content-type:", "Content-type:",
                                "CONTENT-TYPE:"};
    string doc_prefix [5] = '{"application/pdf", "application/msword",
                              "application/vnd.ms-excel", "application/mspowerpoint",
                              "application/postscript"};
    hhs_pkg::kind_t doc_kind [5] = '{hhs_pkg::KIND_PDF, hhs_pkg::KIND_WORD,
                                     hhs_pkg::KIND_EXCEL, hhs_pkg::KIND_POWERPOINT,
                                     hhs_pkg::KIND_POSTSCRIPT};

    // Scanner state mirrored by the predictor
    int unsigned     scan_cnt;
    logic [7:0]      hist [3];
    logic            hdr_done;
    logic            nul_seen;
    int              name_idx [4];
    hhs_pkg::phase_t spell_phase [4];
    logic [4:0]      cand [4];
    int              val_idx [4];
    hhs_pkg::kind_t  spell_kind [4];

    hhs_pkg::out_item_t verdict_q [$];
    logic [7:0]         reply_buf [$];

    function automatic void clear_scan();
        scan_cnt = 0;
        hdr_done = 1'b0;
        nul_seen = 1'b0;
        for (int i = 0; i < 3; i++) hist[i] = BYTE_NUL;
        for (int k = 0; k < 4; k++) begin
            name_idx[k]    = 0;
            spell_phase[k] = hhs_pkg::PH_SEARCH;
            cand[k]        = 5'h1F;
            val_idx[k]     = 0;
            spell_kind[k]  = hhs_pkg::KIND_UNKNOWN;
        end
    endfunction

    // One value character for spelling k: decide on a full prefix, else narrow
    function automatic void value_step(input int k, input logic [7:0] b);
        logic [7:0] lb;
        int         vi;
        vi = val_idx[k];
        lb = (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
        for (int j = 0; j < 5; j++) begin
            if (cand[k][j] && doc_prefix[j].len() == vi) begin
                spell_kind[k]  = doc_kind[j];
                spell_phase[k] = hhs_pkg::PH_DONE;
                return;
            end
        end
        for (int j = 0; j < 5; j++) begin
            if (cand[k][j] && (vi >= doc_prefix[j].len() || doc_prefix[j][vi] != lb))
                cand[k][j] = 1'b0;
        end
        if (cand[k] == 5'd0) begin
            spell_kind[k]  = hhs_pkg::KIND_UNKNOWN;
            spell_phase[k] = hhs_pkg::PH_DONE;
        end else if (vi < 31) begin
            val_idx[k] = vi + 1;
        end
    endfunction

    function automatic void spelling_step(input int k, input logic [7:0] b);
        case (spell_phase[k])
            hhs_pkg::PH_SEARCH: begin
                if (!nul_seen) begin
                    if (name_idx[k] < 13 && b == spelling_txt[k][name_idx[k]])
                        name_idx[k]++;
                    else
                        name_idx[k] = (b == spelling_txt[k][0]) ? 1 : 0;
                    if (name_idx[k] >= 13) spell_phase[k] = hhs_pkg::PH_SKIP;
                end
            end
            hhs_pkg::PH_SKIP: begin
                if (b != BYTE_SP && b != BYTE_TAB) begin
                    spell_phase[k] = hhs_pkg::PH_MATCH;
                    val_idx[k]     = 0;
                    cand[k]        = 5'h1F;
                    value_step(k, b);
                end
            end
            hhs_pkg::PH_MATCH: value_step(k, b);
            default: ;
        endcase
    endfunction

    // Advance the predicted scan by one accepted byte; queue the verdict on the last
    function automatic void scan_reply_byte(input hhs_pkg::in_item_t it);
        logic [7:0]         b;
        logic               two;
        logic               four;
        hhs_pkg::kind_t     kind;
        hhs_pkg::out_item_t res;
        b = it.data_byte;
        if (!hdr_done && scan_cnt < REPLY_LIMIT) begin
            for (int k = 0; k < 4; k++) spelling_step(k, b);
            if (b == BYTE_NUL) nul_seen = 1'b1;
            two  = scan_cnt >= 1 && ((hist[0] == BYTE_CR && b == BYTE_CR) ||
                                     (hist[0] == BYTE_LF && b == BYTE_LF));
            four = scan_cnt >= 3 &&
                   ((hist[2] == BYTE_CR && hist[1] == BYTE_LF && hist[0] == BYTE_CR &&
                     b == BYTE_LF) ||
                    (hist[2] == BYTE_LF && hist[1] == BYTE_CR && hist[0] == BYTE_LF &&
                     b == BYTE_CR));
            hist[2] = hist[1];
            hist[1] = hist[0];
            hist[0] = b;
            scan_cnt++;
            if (two || four) hdr_done = 1'b1;
        end
        if (it.last_byte) begin
            res  = '0;
            kind = hhs_pkg::KIND_UNKNOWN;
            if (hdr_done) begin
                res.header_length = (scan_cnt > LEN_CAP) ? LEN_CAP[24:0] : scan_cnt[24:0];
                // lowest-numbered spelling that was found decides
                for (int k = 3; k >= 0; k--) begin
                    if (spell_phase[k] != hhs_pkg::PH_SEARCH)
                        kind = (spell_phase[k] == hhs_pkg::PH_DONE) ? spell_kind[k]
                                                                    : hhs_pkg::KIND_UNKNOWN;
                end
            end
            res.header_found     = hdr_done;
            res.content_kind     = kind;
            res.needs_conversion = (kind != hhs_pkg::KIND_UNKNOWN);
            verdict_q.push_back(res);
            clear_scan();
        end
    endfunction

    // Offer one item at the falling edge, with random idle cycles ahead of it
    task automatic put_byte(input logic [7:0] b, input logic last);
        hhs_pkg::in_item_t it;
        it.data_byte = b;
        it.last_byte = last;
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        scan_reply_byte(it);
        bytes_sent++;
    endtask

    task automatic append(input string s);
        for (int i = 0; i < s.len(); i++) reply_buf.push_back(s[i]);
    endtask

    task automatic send_reply();
        for (int i = 0; i < reply_buf.size(); i++)
            put_byte(reply_buf[i], i == reply_buf.size() - 1);
        reply_buf.delete();
        replies_sent++;
    endtask

    task automatic send_text(input string s);
        append(s);
        send_reply();
    endtask

    task automatic set_pressure(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // Each boundary form, overlaps, and replies with no boundary
    task automatic test_header_boundaries();
        send_text("\015\015");
        send_text("\012\012");
        send_text("A\015\012\015\012");
        send_text("\012\015\012\015");
        send_text("\015\012\012");
        send_text("\015\012\015\015");
        reply_buf.push_back(BYTE_NUL);
        send_reply();
        reply_buf.push_back(8'hFF);
        send_reply();
    endtask

    // Every spelling, every document type, blanks, case folding, priority
    task automatic test_content_types();
        send_text("content-type:\011application/msword\015\012\015\012");
        send_text("Content-type:  APPLICATION/VND.MS-EXCEL\015\015");
        send_text("CONTENT-TYPE:application/MSPowerPoint\012\015\012\015");
        send_text("Content-Type: \011 Application/PostScript; x\015\012\015\012");
        append("content-type: application/msword\015\012");
        send_text("Content-Type: application/pdf\015\012\015\012");
        send_text("Content-TYPE: application/pdf\012\012");
    endtask

    // Value cut by the end of the header, NUL bytes, bytes after the header
    task automatic test_special_cases();
        send_text("Content-Type: application/pd\012\012");
        send_text("Content-Type:\012\012");
        reply_buf.push_back(BYTE_NUL);
        send_text("Content-Type: application/pdf\012\012");
        append("Content-Type: application/pdf");
        reply_buf.push_back(BYTE_NUL);
        send_text("\012\012");
        append("Content-Type: appli");
        reply_buf.push_back(BYTE_NUL);
        send_text("cation/pdf\015\015");
        send_text("\012\012Content-Type: application/pdf\012\012");
    endtask

    // Short noise replies built from CR, LF, NUL and random bytes
    task automatic test_random_replies();
        int len;
        repeat (6) begin
            len = $urandom_range(1, 8);
            repeat (len) begin
                case ($urandom_range(3))
                    0:       reply_buf.push_back(BYTE_CR);
                    1:       reply_buf.push_back(BYTE_LF);
                    2:       reply_buf.push_back(BYTE_NUL);
                    default: reply_buf.push_back(8'($urandom_range(255)));
                endcase
            end
            send_reply();
        end
    endtask

    // Result channel back-pressure
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic void check_field(input string fname, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
            errors++;
        end
    endfunction

    // Compare each accepted result with the oldest predicted verdict
    always @(posedge aclk) begin
        hhs_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (verdict_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h", $time, m_item);
                errors++;
            end else begin
                want = verdict_q.pop_front();
                check_field("header_found", want.header_found, m_item.header_found);
                check_field("header_length", want.header_length, m_item.header_length);
                check_field("content_kind", want.content_kind, m_item.content_kind);
                check_field("needs_conversion", want.needs_conversion,
                            m_item.needs_conversion);
                results_seen++;
                if (m_item.needs_conversion) typed_seen++;
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("http_header_end_and_type_scan verification failed");
            $finish;
        end
    end

    initial begin
        clear_scan();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        set_pressure(0, 0);
        test_content_types();
        set_pressure(58, 0);
        test_special_cases();
        set_pressure(0, 58);
        test_header_boundaries();
        set_pressure(31, 31);
        test_random_replies();

        // drain
        @(negedge aclk);
        s_valid <= 1'b0;
        set_pressure(0, 0);
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Scanned %0d replies (%0d bytes) under four handshake pressure mixes;",
                 replies_sent, bytes_sent);
        $display("%0d results checked, %0d of them named a document type.",
                 results_seen, typed_seen);
        if (errors == 0) begin
            $display("http_header_end_and_type_scan verification clean");
        end else begin
            $display("http_header_end_and_type_scan verification failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/hhs_pkg.sv
hw/rtl/hhs_spell_cell.sv
hw/rtl/http_header_end_and_type_scan.sv
hw/rtl/hhs_checker.sv
sim/tb_top.sv
